@@ hdl/ptb_pkg.sv @@
package ptb_pkg;

    // Channel layout
    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_W     = 8;
    localparam int COLOR_W  = 16;

    // Config widths
    localparam int GAIN_W   = 24;
    localparam int BLEND_W  = 23;
    localparam int FRAC_W   = 16;
    localparam int GINT_W   = GAIN_W - FRAC_W;

    typedef enum logic [1:0] {
        REG_RED_GAIN,
        REG_GREEN_GAIN,
        REG_BLUE_GAIN,
        REG_BLEND_AMOUNT
    } t_cfg_reg;

    // Divide-by-three by reciprocal, exact for values below 2048
    localparam int          SUM_W      = 10;
    localparam logic [9:0]  DIV3_MUL   = 10'd683;
    localparam int          DIV3_SHIFT = 11;
    localparam int          DIV3_PW    = 20;

    // Divider: 16-bit dividend, 8-bit divisor, four quotient bits per stage
    localparam int DIVD_W     = GINT_W + CH_W;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = DIVD_W / DIV_BITS;

    typedef struct packed {
        logic [DIVD_W-1:0] work;
        logic [CH_W-1:0]   rem;
    } t_div_state;

    // Blend scaling: 100 percent in 7.16, divided as >>16 then /100
    localparam longint unsigned FULL_BLEND = 64'd6553600;
    localparam longint unsigned PCT_DIV    = FULL_BLEND >> FRAC_W;
    localparam int              PCT_SHIFT  = 30;
    localparam int              PCT_MUL_W  = 24;
    localparam logic [PCT_MUL_W-1:0] PCT_MUL =
        PCT_MUL_W'(((64'd1 << PCT_SHIFT) + PCT_DIV - 64'd1) / PCT_DIV);
    localparam int BPROD_W = DIVD_W + BLEND_W;
    localparam int SCL_W   = BPROD_W - FRAC_W;
    localparam int QPROD_W = SCL_W + PCT_MUL_W;
    localparam int QUO_W   = 17;

    // Clamp and repack
    localparam logic [CH_W-1:0] CH_MAX      = 8'd255;
    localparam int              CH_LIMIT    = 256;
    localparam logic [CH_W-1:0] REPACK_MASK = 8'hF1;

    // Pipeline stage numbers
    localparam int ST_IN    = 0;
    localparam int ST_MEAN  = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_DIV   = 3;
    localparam int ST_DIFF  = ST_DIV + DIV_STAGES;
    localparam int ST_SCALE = ST_DIFF + 1;
    localparam int ST_QUOT  = ST_SCALE + 1;
    localparam int ST_OUT   = ST_QUOT + 1;
    localparam int NUM_ST   = ST_OUT + 1;

    // Widen a 5-bit channel of the packed color to 8 bits
    function automatic logic [CH_W-1:0] widen(logic [COLOR_W-1:0] color, int c);
        logic [CH_W-1:0] v;
        case (c)
            CH_RED:   v = {color[15:11], 3'b000};
            CH_GREEN: v = {color[10:6], 3'b000};
            CH_BLUE:  v = {color[5:1], 3'b000};
            default:  v = '0;
        endcase
        return v;
    endfunction

    // Four restoring division steps
    function automatic t_div_state div_step(t_div_state st, logic [CH_W-1:0] d);
        logic [CH_W:0] trial;
        t_div_state    res;
        res = st;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial    = {res.rem, res.work[DIVD_W-1]};
            res.work = {res.work[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
                trial       = trial - {1'b0, d};
                res.work[0] = 1'b1;
            end
            res.rem = trial[CH_W-1:0];
        end
        return res;
    endfunction

    // Repack channels with the 0xF1 masks; fields may overlap
    function automatic logic [COLOR_W-1:0] repack(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                  logic [CH_W-1:0] b, logic alpha);
        logic [CH_W-1:0] rm;
        logic [CH_W-1:0] gm;
        logic [CH_W-1:0] bm;
        rm = r & REPACK_MASK;
        gm = g & REPACK_MASK;
        bm = b & REPACK_MASK;
        return {rm, 8'b0} | {5'b0, gm, 3'b0} | {10'b0, bm[7:2]} | {15'b0, alpha};
    endfunction

endpackage

@@ hdl/palette_tint_blend_unit.sv @@
// Palette tint and blend, eleven register stages.
// Throughput: one request per cycle while the output is not stalled; the four divider
// stages (four quotient bits each) and the two blend multipliers set the pipeline depth.
// Reset: synchronous, active low; clears config registers and all valid bits.
// A config write reaches the derived divisor through r_gain, r_gsum_hi and r_divisor.
module palette_tint_blend_unit
    import ptb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [GAIN_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [COLOR_W-1:0]  i_source_color,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [COLOR_W-1:0]  o_tinted_color
);

    logic [GAIN_W-1:0]  r_gain [NUM_CH];
    logic [BLEND_W-1:0] r_blend;
    logic [SUM_W-1:0]   r_gsum_hi;
    logic [CH_W-1:0]    r_divisor;
    logic [GAIN_W+1:0]  gsum;
    logic [DIV3_PW-1:0] dprod;

    logic [NUM_ST-1:0]  r_vld;
    logic [NUM_ST-1:0]  prev_vld;
    logic [NUM_ST-1:0]  load;
    logic [COLOR_W-1:0] r_col [ST_OUT];

    logic [CH_W-1:0]    r_mean;
    logic [SUM_W-1:0]   csum;
    logic [DIV3_PW-1:0] mprod;
    logic [DIVD_W-1:0]  r_prod [NUM_CH];
    t_div_state         r_div  [DIV_STAGES][NUM_CH];
    t_div_state         div_in [DIV_STAGES][NUM_CH];
    logic [DIVD_W-1:0]  r_mag  [NUM_CH];
    logic               r_neg  [3][NUM_CH];
    logic [BPROD_W-1:0] r_bprod [NUM_CH];
    logic [QPROD_W-1:0] qprod  [NUM_CH];
    logic [QUO_W-1:0]   r_quo  [NUM_CH];
    logic [CH_W-1:0]    ch_out [NUM_CH];
    logic [COLOR_W-1:0] r_tinted;

    // Config registers; every write is taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_gain[c] <= '0;
            end
            r_blend <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_RED_GAIN:     r_gain[CH_RED]   <= i_cfg_data;
                REG_GREEN_GAIN:   r_gain[CH_GREEN] <= i_cfg_data;
                REG_BLUE_GAIN:    r_gain[CH_BLUE]  <= i_cfg_data;
                REG_BLEND_AMOUNT: r_blend          <= i_cfg_data[BLEND_W-1:0];
            endcase
        end
    end

    // Divisor: integer part of the mean gain, (sum >> 16) / 3
    assign gsum  = {2'b00, r_gain[CH_RED]} + {2'b00, r_gain[CH_GREEN]}
                 + {2'b00, r_gain[CH_BLUE]};
    assign dprod = r_gsum_hi * DIV3_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsum_hi <= '0;
            r_divisor <= '0;
        end else begin
            r_gsum_hi <= gsum[GAIN_W+1:FRAC_W];
            r_divisor <= dprod[DIV3_SHIFT +: CH_W];
        end
    end

    // Per-stage load enables: a stage loads when empty or when it drains
    always_comb begin
        load[NUM_ST-1] = !r_vld[NUM_ST-1] || i_out_ready;
        for (int s = NUM_ST - 2; s >= 0; s--) begin
            load[s] = !r_vld[s] || load[s+1];
        end
    end

    assign prev_vld   = {r_vld[NUM_ST-2:0], i_in_valid};
    assign o_in_ready = load[ST_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NUM_ST; s++) begin
                if (load[s]) begin
                    r_vld[s] <= prev_vld[s];
                end
            end
        end
    end

    // Carry the source color down to the output stage
    always_ff @(posedge i_clk) begin
        if (load[ST_IN]) begin
            r_col[ST_IN] <= i_source_color;
        end
        for (int s = 1; s < ST_OUT; s++) begin
            if (load[s]) begin
                r_col[s] <= r_col[s-1];
            end
        end
    end

    // Mean of the widened channels, truncated
    assign csum  = SUM_W'(widen(r_col[ST_IN], CH_RED)) + SUM_W'(widen(r_col[ST_IN], CH_GREEN))
                 + SUM_W'(widen(r_col[ST_IN], CH_BLUE));
    assign mprod = csum * DIV3_MUL;

    always_ff @(posedge i_clk) begin
        if (load[ST_MEAN]) begin
            r_mean <= mprod[DIV3_SHIFT +: CH_W];
        end
    end

    // Gain integer part times mean
    always_ff @(posedge i_clk) begin
        if (load[ST_MUL]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= r_gain[c][GAIN_W-1:FRAC_W] * r_mean;
            end
        end
    end

    // Divider pipeline: target = product / divisor
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            div_in[0][c] = '{work: r_prod[c], rem: '0};
            for (int s = 1; s < DIV_STAGES; s++) begin
                div_in[s][c] = r_div[s-1][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (load[ST_DIV+s]) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_div[s][c] <= div_step(div_in[s][c], r_divisor);
                end
            end
        end
    end

    // Magnitude of target minus channel
    always_ff @(posedge i_clk) begin
        if (load[ST_DIFF]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_div[DIV_STAGES-1][c].work >= DIVD_W'(widen(r_col[ST_DIFF-1], c))) begin
                    r_mag[c] <= r_div[DIV_STAGES-1][c].work
                              - DIVD_W'(widen(r_col[ST_DIFF-1], c));
                end else begin
                    r_mag[c] <= DIVD_W'(widen(r_col[ST_DIFF-1], c))
                              - r_div[DIV_STAGES-1][c].work;
                end
            end
        end
    end

    // Take the sign of target minus channel and advance it with the step
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (load[ST_DIFF]) begin
                r_neg[0][c] <= (r_div[DIV_STAGES-1][c].work
                                < DIVD_W'(widen(r_col[ST_DIFF-1], c)));
            end
            if (load[ST_SCALE]) begin
                r_neg[1][c] <= r_neg[0][c];
            end
            if (load[ST_QUOT]) begin
                r_neg[2][c] <= r_neg[1][c];
            end
        end
    end

    // Scale the magnitude by the blend amount
    always_ff @(posedge i_clk) begin
        if (load[ST_SCALE]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_bprod[c] <= r_mag[c] * r_blend;
            end
        end
    end

    // Drop the fraction, then divide by 100 through the reciprocal
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            qprod[c] = r_bprod[c][BPROD_W-1:FRAC_W] * PCT_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[ST_QUOT]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_quo[c] <= qprod[c][PCT_SHIFT +: QUO_W];
            end
        end
    end

    // Apply the step, clamp to 0..255, pass channels through on a zero divisor
    always_comb begin
        logic [CH_W-1:0]  ch;
        logic [QUO_W:0]   up;
        for (int c = 0; c < NUM_CH; c++) begin
            ch = widen(r_col[ST_OUT-1], c);
            up = {{(QUO_W+1-CH_W){1'b0}}, ch} + {1'b0, r_quo[c]};
            if (r_divisor == '0) begin
                ch_out[c] = ch;
            end else if (r_neg[2][c]) begin
                if (r_quo[c] > QUO_W'(ch)) begin
                    ch_out[c] = '0;
                end else begin
                    ch_out[c] = ch - r_quo[c][CH_W-1:0];
                end
            end else if (up >= (QUO_W+1)'(CH_LIMIT)) begin
                ch_out[c] = CH_MAX;
            end else begin
                ch_out[c] = up[CH_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load[ST_OUT]) begin
            r_tinted <= repack(ch_out[CH_RED], ch_out[CH_GREEN], ch_out[CH_BLUE],
                               r_col[ST_OUT-1][0]);
        end
    end

    assign o_out_valid    = r_vld[ST_OUT];
    assign o_tinted_color = r_tinted;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          RAND_PHASES  = 12;
    localparam int          PHASE_ITEMS  = 160;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // Predict the tinted color of each accepted request and check results in order
    class t_tint_scoreboard;
        logic [GAIN_W-1:0]  gain [NUM_CH];
        logic [BLEND_W-1:0] blend;
        logic [COLOR_W-1:0] pending_colors [$];
        int unsigned        mismatches;

        function new();
            foreach (gain[k]) gain[k] = '0;
            blend      = '0;
            mismatches = 0;
        endfunction

        function void mirror_register(t_cfg_reg idx, logic [GAIN_W-1:0] data);
            case (idx)
                REG_RED_GAIN:     gain[CH_RED] = data;
                REG_GREEN_GAIN:   gain[CH_GREEN] = data;
                REG_BLUE_GAIN:    gain[CH_BLUE] = data;
                REG_BLEND_AMOUNT: blend = data[BLEND_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] tint_color(logic [COLOR_W-1:0] c);
            longint            ch [NUM_CH];
            longint            mean;
            longint            divisor;
            longint            target;
            longint            v;
            longint unsigned   gain_sum;
            logic [CH_W-1:0]   res [NUM_CH];
            logic [COLOR_W-1:0] word;
            // widen 5-bit channels to 8 bits, low bits zero
            ch[CH_RED]   = {c[15:11], 3'b000};
            ch[CH_GREEN] = {c[10:6], 3'b000};
            ch[CH_BLUE]  = {c[5:1], 3'b000};
            mean     = (ch[CH_RED] + ch[CH_GREEN] + ch[CH_BLUE]) / 3;
            gain_sum = gain[CH_RED] + gain[CH_GREEN] + gain[CH_BLUE];
            divisor  = longint'((gain_sum / 3) >> FRAC_W);
            for (int k = 0; k < NUM_CH; k++) begin
                if (divisor != 0) begin
                    // move the channel toward its target, then clamp
                    target = (longint'(gain[k] >> FRAC_W) * mean) / divisor;
                    v = ch[k] + ((target - ch[k]) * longint'(blend)) / longint'(FULL_BLEND);
                    if (v >= CH_LIMIT)
                        v = CH_MAX;
                    if (v < 0)
                        v = 0;
                end else begin
                    v = ch[k];
                end
                res[k] = v[CH_W-1:0];
            end
            // masks may overlap the neighboring fields
            word = (COLOR_W'(res[CH_RED] & REPACK_MASK) << 8)
                 | (COLOR_W'(res[CH_GREEN] & REPACK_MASK) << 3)
                 | (COLOR_W'(res[CH_BLUE] & REPACK_MASK) >> 2)
                 | COLOR_W'(c[0]);
            return word;
        endfunction

        function void note_request(logic [COLOR_W-1:0] c);
            pending_colors.push_back(tint_color(c));
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [COLOR_W-1:0] got);
            logic [COLOR_W-1:0] predicted;
            if (pending_colors.size() == 0) begin
                report_mismatch($sformatf("tinted color %h with nothing pending", got));
            end else begin
                predicted = pending_colors.pop_front();
                if (got !== predicted)
                    report_mismatch($sformatf("tinted color %h, predicted %h", got, predicted));
            end
        endtask
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_index    = '0;
    logic [GAIN_W-1:0]    i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [COLOR_W-1:0]   i_source_color = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [COLOR_W-1:0]   o_tinted_color;

    int unsigned          cycle_count    = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    t_tint_scoreboard     tint_sb        = new();

    logic [COLOR_W-1:0] directed_colors [24] = '{
        16'h0000, 16'hFFFF, 16'hF800, 16'h07C1,
        16'h003E, 16'hFFFE, 16'hAAAA, 16'h5555,
        16'h0841, 16'hF83F, 16'h07FE, 16'hFFC1,
        16'hFFFF, 16'h0000, 16'h8421, 16'h7BDE,
        16'hF800, 16'hFFFF, 16'h003F, 16'h07C0,
        16'h1234, 16'hFFFF, 16'h0001, 16'hEDCB
    };

    palette_tint_blend_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_color (i_source_color),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tinted_color (o_tinted_color)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Check accepted results, then pick the ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tint_sb.check_result(o_tinted_color);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic void set_idle_mode(t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 57;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 57;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 21;
                recv_stall_pct = 21;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    // Hold the color request until accepted, after a random idle gap
    task automatic send_color(input logic [COLOR_W-1:0] c);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_source_color <= c;
        do @(posedge i_clk); while (!o_in_ready);
        tint_sb.note_request(c);
    endtask

    task automatic program_register(input t_cfg_reg idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tint_sb.mirror_register(idx, data);
    endtask

    // Drain the pipeline, then load all four registers
    task automatic apply_setting(input logic [GAIN_W-1:0] red, input logic [GAIN_W-1:0] green,
                                 input logic [GAIN_W-1:0] blue, input logic [GAIN_W-1:0] amount);
        i_in_valid <= 1'b0;
        while (tint_sb.pending_colors.size() != 0)
            @(posedge i_clk);
        program_register(REG_RED_GAIN, red);
        program_register(REG_GREEN_GAIN, green);
        program_register(REG_BLUE_GAIN, blue);
        program_register(REG_BLEND_AMOUNT, amount);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom_range(0, 24'hFFFFFF));
            default: return GAIN_W'($urandom_range(0, 24'h3FFFF));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_blend();
        case ($urandom_range(5))
            0:       return '0;
            1:       return GAIN_W'(FULL_BLEND);
            2:       return 24'h7FFFFF;
            3:       return GAIN_W'($urandom_range(0, 6553600));
            default: return GAIN_W'($urandom_range(0, 24'h7FFFFF));
        endcase
    endfunction

    // Mostly full-range colors, some with every channel at zero or full scale
    function automatic logic [COLOR_W-1:0] pick_color();
        logic [COLOR_W-1:0] c;
        c = COLOR_W'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(7) == 0) begin
            c[15:11] = {5{c[15]}};
            c[10:6]  = {5{c[10]}};
            c[5:1]   = {5{c[5]}};
        end
        return c;
    endfunction

    task automatic send_directed(input int first);
        for (int k = first; k < first + 4; k++)
            send_color(directed_colors[k]);
    endtask

    initial begin
        set_idle_mode(IDLE_NONE);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero divisor: channels pass through
        apply_setting(24'h000000, 24'h000000, 24'h000000, 24'd0);
        send_directed(0);
        // divisor of one, half blend
        apply_setting(24'h010000, 24'h010000, 24'h010000, 24'd3276800);
        send_directed(4);
        // largest gains, blend above full scale
        apply_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF);
        send_directed(8);
        // red overshoots and clamps high, others pulled to zero
        apply_setting(24'hFFFFFF, 24'h000000, 24'h000000, 24'd6553600);
        send_directed(12);
        // red driven below zero by the oversized blend
        apply_setting(24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF);
        send_directed(16);
        // nonzero divisor with no blend
        apply_setting(24'h123456, 24'hABCDEF, 24'h00FFFF, 24'd0);
        send_directed(20);

        // random phases, rotating through the idle modes
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_blend());
            set_idle_mode(t_idle_mode'(phase % 4));
            repeat (PHASE_ITEMS)
                send_color(pick_color());
        end

        i_in_valid <= 1'b0;
        while (tint_sb.pending_colors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tint_sb.pending_colors.size() != 0)
            tint_sb.report_mismatch("results still pending at end of run");

        if (tint_sb.mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ palette_tint_blend_unit.f @@
hdl/ptb_pkg.sv
hdl/palette_tint_blend_unit.sv
tb/tb_top.sv
